FILE: sv/tgdt_pkg.sv
`default_nettype none

package tgdt_pkg;

  // Number of object slots kept on chip (1 to 8, as slots are 3 bits wide).
  localparam int NUM_OBJECTS = 8;
  localparam int IDX_W       = (NUM_OBJECTS > 1) ? $clog2(NUM_OBJECTS) : 1;
  localparam int SLOT_EXT_W  = 6;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_OBJECTS - 1);

  // Event kinds on the input channel
  localparam logic [1:0] FUNC_TAP   = 2'd0;
  localparam logic [1:0] FUNC_MOVED = 2'd1;
  localparam logic [1:0] FUNC_STOP  = 2'd2;
  localparam logic [1:0] FUNC_TICK  = 2'd3;

  // Result kinds
  localparam logic [1:0] KIND_STATUS = 2'd0;
  localparam logic [1:0] KIND_TAP    = 2'd1;
  localparam logic [1:0] KIND_DOUBLE = 2'd2;
  localparam logic [1:0] KIND_DIRTY  = 2'd3;

  // Configuration register indexes
  localparam logic [2:0] CFG_FILTER_ENABLE = 3'd0;
  localparam logic [2:0] CFG_IS_PHYSICAL   = 3'd1;
  localparam logic [2:0] CFG_HOLD_WINDOW   = 3'd2;
  localparam logic [2:0] CFG_DOUBLE_WINDOW = 3'd3;
  localparam logic [2:0] CFG_IGNORE_WINDOW = 3'd4;
  localparam logic [2:0] CFG_IGNORE_ENABLE = 3'd5;

  localparam logic [15:0] HOLD_WINDOW_RST   = 16'd75;
  localparam logic [15:0] DOUBLE_WINDOW_RST = 16'd500;
  localparam logic [15:0] IGNORE_WINDOW_RST = 16'd500;

  // Shared adder operations
  typedef logic alu_op_t;
  localparam alu_op_t ALU_ADD = 1'b0;
  localparam alu_op_t ALU_LT  = 1'b1;

  typedef struct packed {
    logic        filter_enable;
    logic        is_physical;
    logic [15:0] hold_window_ms;
    logic [15:0] double_tap_window_ms;
    logic [15:0] ignore_move_window_ms;
    logic        ignore_move_enable;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  slot;
    logic [31:0] tap_data;
    logic        ignore_movement;
    logic        last;
  } res_t;

  function automatic logic [IDX_W-1:0] slot_to_idx(input logic [2:0] s);
    logic [SLOT_EXT_W-1:0] t;
    t = SLOT_EXT_W'(s);
    return t[IDX_W-1:0];
  endfunction

  function automatic logic [2:0] idx_to_slot(input logic [IDX_W-1:0] i);
    logic [SLOT_EXT_W-1:0] t;
    t = SLOT_EXT_W'(i);
    return t[2:0];
  endfunction

endpackage

`default_nettype wire

FILE: sv/tgdt_alu.sv
`default_nettype none

module tgdt_alu (
  input  tgdt_pkg::alu_op_t op,
  input  logic [31:0]       a,
  input  logic [31:0]       b,
  output logic [31:0]       sum,
  output logic              lt
);
  import tgdt_pkg::*;

  logic [31:0] b_eff;
  logic [32:0] full;

  // One 32-bit adder: a + b, or a - b whose borrow gives a < b.
  assign b_eff = (op == ALU_LT) ? ~b : b;
  assign full  = {1'b0, a} + {1'b0, b_eff} + {32'd0, (op == ALU_LT)};
  assign sum   = full[31:0];
  assign lt    = (op == ALU_LT) & ~full[32];

endmodule

`default_nettype wire

FILE: sv/tgdt_core.sv
`default_nettype none

module tgdt_core (
  input  logic             clk,
  input  logic             rst,
  input  tgdt_pkg::cfg_t   cfg,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [1:0]       func,
  input  logic [2:0]       object_slot,
  input  logic             object_known,
  input  logic [31:0]      now_ms,
  input  logic [31:0]      tap_data,
  output logic             res_valid,
  input  logic             res_ready,
  output tgdt_pkg::res_t   res
);
  import tgdt_pkg::*;

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_DISPATCH  = 4'd1;
  localparam logic [3:0] S_TICK_REL  = 4'd2;
  localparam logic [3:0] S_TICK_WALK = 4'd3;
  localparam logic [3:0] S_TAP_FWD   = 4'd4;
  localparam logic [3:0] S_TAP_CHK   = 4'd5;
  localparam logic [3:0] S_TAP_DD    = 4'd6;
  localparam logic [3:0] S_TAP_IGN   = 4'd7;
  localparam logic [3:0] S_STATUS    = 4'd8;

  logic [3:0]       state;
  logic [1:0]       func_q;
  logic [2:0]       slot_q;
  logic             known_q;
  logic [31:0]      now_q;
  logic [31:0]      data_q;
  logic [IDX_W-1:0] idx;

  logic        held_valid;
  logic [31:0] held_tap_word;
  logic [2:0]  held_tap_slot;
  logic [31:0] release_time;

  logic [31:0] double_deadline [NUM_OBJECTS];
  logic [31:0] ignore_deadline [NUM_OBJECTS];
  logic [NUM_OBJECTS-1:0] moving_flag;
  logic [NUM_OBJECTS-1:0] ignoring_flag;

  logic             slot_ok;
  logic [IDX_W-1:0] sidx;
  logic             filter_on;
  logic             advance;

  alu_op_t     alu_op;
  logic [31:0] alu_a;
  logic [31:0] alu_b;
  logic [31:0] alu_sum;
  logic        alu_lt;

  assign slot_ok   = {{(SLOT_EXT_W-3){1'b0}}, slot_q} < SLOT_EXT_W'(NUM_OBJECTS);
  assign sidx      = slot_to_idx(slot_q);
  assign filter_on = cfg.filter_enable & cfg.is_physical;
  assign in_ready  = (state == S_IDLE);
  assign advance   = !res_valid || res_ready;

  tgdt_alu u_alu (
    .op  (alu_op),
    .a   (alu_a),
    .b   (alu_b),
    .sum (alu_sum),
    .lt  (alu_lt)
  );

  always_comb begin
    alu_op = ALU_ADD;
    alu_a  = now_q;
    alu_b  = '0;
    case (state)
      S_TICK_REL: begin
        alu_op = ALU_LT;
        alu_a  = release_time;
      end
      S_TICK_WALK: begin
        alu_op = ALU_LT;
        alu_b  = ignore_deadline[idx];
      end
      S_TAP_FWD: alu_b = {16'd0, cfg.hold_window_ms};
      S_TAP_CHK: begin
        alu_op = ALU_LT;
        alu_b  = double_deadline[sidx];
      end
      S_TAP_DD:  alu_b = {16'd0, cfg.double_tap_window_ms};
      S_TAP_IGN: alu_b = {16'd0, cfg.ignore_move_window_ms};
      S_STATUS: begin
        alu_op = ALU_LT;
        alu_b  = ignore_deadline[sidx];
      end
      default: alu_b = '0;
    endcase
    if (state == S_TICK_REL) begin
      alu_b = now_q;
    end
  end

  always_comb begin
    res_valid = 1'b0;
    res       = '0;
    case (state)
      S_TICK_REL: begin
        if (held_valid && alu_lt) begin
          res_valid    = 1'b1;
          res.kind     = KIND_TAP;
          res.slot     = held_tap_slot;
          res.tap_data = held_tap_word;
        end
      end
      S_TICK_WALK: begin
        if (ignoring_flag[idx] && !alu_lt) begin
          res_valid = 1'b1;
          res.kind  = KIND_DIRTY;
          res.slot  = idx_to_slot(idx);
        end
      end
      S_TAP_FWD: begin
        if (!filter_on) begin
          res_valid    = 1'b1;
          res.kind     = KIND_TAP;
          res.slot     = slot_q;
          res.tap_data = data_q;
        end
      end
      S_TAP_CHK: begin
        if (!moving_flag[sidx] && alu_lt) begin
          res_valid = 1'b1;
          res.kind  = KIND_DOUBLE;
          res.slot  = slot_q;
        end
      end
      S_STATUS: begin
        res_valid           = 1'b1;
        res.kind            = KIND_STATUS;
        res.slot            = slot_q;
        res.ignore_movement = slot_ok & cfg.ignore_move_enable & alu_lt;
        res.last            = 1'b1;
      end
      default: res_valid = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      idx           <= '0;
      held_valid    <= 1'b0;
      held_tap_word <= '0;
      held_tap_slot <= '0;
      release_time  <= '0;
      moving_flag   <= '0;
      ignoring_flag <= '0;
      for (int i = 0; i < NUM_OBJECTS; i++) begin
        double_deadline[i] <= '0;
        ignore_deadline[i] <= '0;
      end
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            func_q  <= func;
            slot_q  <= object_slot;
            known_q <= object_known;
            now_q   <= now_ms;
            data_q  <= tap_data;
            state   <= S_DISPATCH;
          end
        end
        S_DISPATCH: begin
          if (func_q == FUNC_TICK) begin
            state <= S_TICK_REL;
          end else if (known_q && slot_ok) begin
            unique case (func_q)
              FUNC_TAP:   state <= S_TAP_FWD;
              FUNC_MOVED: begin
                if (double_deadline[sidx] == '0) begin
                  moving_flag[sidx] <= 1'b1;
                end
                state <= S_STATUS;
              end
              default: begin
                moving_flag[sidx] <= 1'b0;
                state             <= S_STATUS;
              end
            endcase
          end else begin
            state <= S_STATUS;
          end
        end
        S_TICK_REL: begin
          if (advance) begin
            if (held_valid && alu_lt) begin
              held_valid <= 1'b0;
            end
            idx   <= '0;
            state <= S_TICK_WALK;
          end
        end
        S_TICK_WALK: begin
          if (advance) begin
            if (ignoring_flag[idx] && !alu_lt) begin
              ignoring_flag[idx] <= 1'b0;
            end
            if (idx == LAST_IDX) begin
              state <= S_STATUS;
            end else begin
              idx <= idx + 1'b1;
            end
          end
        end
        S_TAP_FWD: begin
          if (advance) begin
            if (filter_on) begin
              if (!held_valid) begin
                release_time <= alu_sum;
              end
              held_valid    <= 1'b1;
              held_tap_word <= data_q;
              held_tap_slot <= slot_q;
            end
            state <= S_TAP_CHK;
          end
        end
        S_TAP_CHK: begin
          if (advance) begin
            if (moving_flag[sidx]) begin
              double_deadline[sidx] <= '0;
              state                 <= S_STATUS;
            end else if (alu_lt) begin
              double_deadline[sidx] <= '0;
              ignoring_flag[sidx]   <= 1'b0;
              state                 <= S_STATUS;
            end else begin
              state <= S_TAP_DD;
            end
          end
        end
        S_TAP_DD: begin
          double_deadline[sidx] <= alu_sum;
          state                 <= S_TAP_IGN;
        end
        S_TAP_IGN: begin
          ignore_deadline[sidx] <= alu_sum;
          ignoring_flag[sidx]   <= 1'b1;
          state                 <= S_STATUS;
        end
        S_STATUS: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("accepted a second item while busy");

  a_last_is_status: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.last |-> res.kind == KIND_STATUS)
    else $error("last result is not a status");

  a_idle_after_last: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_ready && res.last |=> in_ready)
    else $error("not ready after final result");

  a_release_only_on_tick: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && $fell(held_valid) |->
      $past(res_valid && res_ready && res.kind == KIND_TAP && state == S_TICK_REL))
    else $error("held tap dropped without release");
`endif

endmodule

`default_nettype wire

FILE: sv/tap_group_and_double_tap_filter.sv
`default_nettype none

// Tap grouping and double-tap filter. Items are tap, moved, stopped-moving
// and tick events stamped with a 32-bit millisecond time; each produces up
// to ten results, always ending with a status result (last = 1) for the
// event's slot. Only one item is in flight: in_ready drops after a transfer
// and rises again once the status result has left the core. A single 32-bit
// adder/comparator is reused step by step by a small sequencer. A tick
// checks the held tap's release time, then scans the ignore deadlines one
// slot per cycle while the result side does not stall; a tap is forwarded
// or held, checked for a double tap and may set new deadlines. Results pass
// through a one-entry output register, so the core keeps working on steps
// that emit no result while a finished result waits. Configuration writes
// take effect at once and must only be made while no item is in flight.
module tap_group_and_double_tap_filter (
  input  logic        clk,
  input  logic        rst,
  // configuration write port
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  // event channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  func,
  input  logic [2:0]  object_slot,
  input  logic        object_known,
  input  logic [31:0] now_ms,
  input  logic [31:0] tap_data,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  kind,
  output logic [2:0]  out_slot,
  output logic [31:0] out_tap_data,
  output logic        ignore_movement,
  output logic        last
);
  import tgdt_pkg::*;

  cfg_t cfg;
  res_t res;
  res_t res_q;
  logic res_valid;
  logic res_ready;

  // Configuration registers; indexes beyond the list are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.filter_enable         <= 1'b1;
      cfg.is_physical           <= 1'b1;
      cfg.hold_window_ms        <= HOLD_WINDOW_RST;
      cfg.double_tap_window_ms  <= DOUBLE_WINDOW_RST;
      cfg.ignore_move_window_ms <= IGNORE_WINDOW_RST;
      cfg.ignore_move_enable    <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FILTER_ENABLE: cfg.filter_enable         <= cfg_data[0];
        CFG_IS_PHYSICAL:   cfg.is_physical           <= cfg_data[0];
        CFG_HOLD_WINDOW:   cfg.hold_window_ms        <= cfg_data;
        CFG_DOUBLE_WINDOW: cfg.double_tap_window_ms  <= cfg_data;
        CFG_IGNORE_WINDOW: cfg.ignore_move_window_ms <= cfg_data;
        CFG_IGNORE_ENABLE: cfg.ignore_move_enable    <= cfg_data[0];
        default:           cfg.is_physical           <= cfg.is_physical;
      endcase
    end
  end

  // Sequencer with the per-slot state and the shared adder.
  tgdt_core u_core (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .func         (func),
    .object_slot  (object_slot),
    .object_known (object_known),
    .now_ms       (now_ms),
    .tap_data     (tap_data),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .res          (res)
  );

  // Output register: load whenever it is empty or its result is being taken.
  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      res_q <= res;
    end
  end

  assign kind            = res_q.kind;
  assign out_slot        = res_q.slot;
  assign out_tap_data    = res_q.tap_data;
  assign ignore_movement = res_q.ignore_movement;
  assign last            = res_q.last;

endmodule

`default_nettype wire
